### rtl/thct_pkg.sv
// ----------------------------------------------------------------------------
// thct_pkg
// Shared types and constants for the tuple hit-count table: beat layouts,
// table geometry and the storage write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package thct_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W  = 24;
   localparam int MODE_W  = 2;
   localparam int KIND_W  = 2;
   localparam int FRAME_W = 31;
   localparam int TOTAL_W = 32;
   localparam int SLOT_W  = 10;
   localparam int USE_W   = 11;

   typedef struct packed {
      logic [ADDR_W-1:0]  site_address;
      logic [ADDR_W-1:0]  target_address;
      logic [MODE_W-1:0]  mode_bits;
      logic [KIND_W-1:0]  event_kind;
      logic               clean_outcome;
      logic [FRAME_W-1:0] frame_number;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic               inserted;
      logic               dropped;
      logic [TOTAL_W-1:0] clean_total;
      logic [TOTAL_W-1:0] bail_total;
      logic [USE_W-1:0]   entries_in_use;
      logic [TOTAL_W-1:0] dropped_total;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] site;
      logic [ADDR_W-1:0] target;
      logic [MODE_W-1:0] mode;
   } key_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] clean;
      logic [TOTAL_W-1:0] bail;
   } stats_type;

   typedef struct packed {
      logic               key_we;
      logic               stats_we;
      logic [IDX_W-1:0]   addr;
      key_type            key;
      stats_type          stats;
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
   } wr_type;

endpackage

`default_nettype wire

### rtl/thct_table.sv
// ----------------------------------------------------------------------------
// thct_table
// Entry storage: key, counter, origin and last-frame memories. One write
// port, one registered read port for keys and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module thct_table (
   input  wire logic                         clock,
   input  wire thct_pkg::wr_type             wr,
   input  wire logic [thct_pkg::IDX_W-1:0]   rd_addr,
   output thct_pkg::key_type                 rd_key,
   output thct_pkg::stats_type               rd_stats
);
   import thct_pkg::*;

   key_type                    key_mem    [TABLE_ENTRIES];
   stats_type                  stats_mem  [TABLE_ENTRIES];
   logic [KIND_W+FRAME_W-1:0]  origin_mem [TABLE_ENTRIES];
   logic [FRAME_W-1:0]         last_mem   [TABLE_ENTRIES];

   key_type   rd_key_ff;
   stats_type rd_stats_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.addr]    <= wr.key;
         origin_mem[wr.addr] <= {wr.kind, wr.frame};
      end
      if (wr.stats_we) begin
         stats_mem[wr.addr] <= wr.stats;
         last_mem[wr.addr]  <= wr.frame;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_stats_ff <= stats_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_stats = rd_stats_ff;

endmodule

`default_nettype wire

### rtl/tuple_hit_count_table.sv
// ----------------------------------------------------------------------------
// tuple_hit_count_table
// Lookup-or-insert statistics table keyed on site, target and mode.
//
//   channel  direction  payload   handshake
//   req      in         req_type  req_valid / req_stall
//   rsp      out        rsp_type  rsp_valid / rsp_stall
//
// An event runs a linear scan that reads one stored key per cycle
// through the single table read port, then commits through the shared
// saturating incrementer.
// Reset clears the entry count and drop count; no clearing pass is run.
// A result beat waits in the output register; a new event is taken
// meanwhile, and its commit holds while the previous result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tuple_hit_count_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire thct_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output thct_pkg::rsp_type      rsp_data
);
   import thct_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_type;
   typedef enum logic [1:0] {OUT_HIT, OUT_INSERT, OUT_DROP} outcome_type;

   state_type          state_ff, state_in;
   outcome_type        outcome_ff, outcome_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [TOTAL_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [TOTAL_W-1:0] clean_ff, clean_in;
   logic [TOTAL_W-1:0] bail_ff, bail_in;

   wr_type             wr;
   key_type            rd_key;
   stats_type          rd_stats;
   key_type            req_key;
   logic               match;
   logic [TOTAL_W-1:0] inc_src;
   logic [TOTAL_W-1:0] inc_out;
   logic [CNT_W-1:0]   used_next;
   logic [TOTAL_W-1:0] clean_next;
   logic [TOTAL_W-1:0] bail_next;

   thct_table u_table (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (scan_ff[IDX_W-1:0]),
      .rd_key   (rd_key),
      .rd_stats (rd_stats)
   );

   assign req_key = '{site:   req_ff.site_address,
                      target: req_ff.target_address,
                      mode:   req_ff.mode_bits};
   assign match   = cmp_valid_ff && (rd_key == req_key);

   always_comb begin
      case (outcome_ff)
         OUT_DROP: inc_src = drop_ff;
         default:  inc_src = req_ff.clean_outcome ? clean_ff : bail_ff;
      endcase
      inc_out = (inc_src == {TOTAL_W{1'b1}}) ? inc_src : inc_src + TOTAL_W'(1);
   end

   assign clean_next = req_ff.clean_outcome ? inc_out : clean_ff;
   assign bail_next  = req_ff.clean_outcome ? bail_ff : inc_out;
   assign used_next  = (outcome_ff == OUT_INSERT) ? used_ff + CNT_W'(1) : used_ff;

   always_comb begin
      state_in     = state_ff;
      outcome_in   = outcome_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      used_in      = used_ff;
      drop_in      = drop_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      slot_in      = slot_ff;
      clean_in     = clean_ff;
      bail_in      = bail_ff;

      wr           = '0;
      wr.addr      = slot_ff;
      wr.key       = req_key;
      wr.stats     = '{clean: clean_next, bail: bail_next};
      wr.kind      = req_ff.event_kind;
      wr.frame     = req_ff.frame_number;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               scan_in      = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               outcome_in   = OUT_HIT;
               slot_in      = cmp_idx_ff;
               clean_in     = rd_stats.clean;
               bail_in      = rd_stats.bail;
               cmp_valid_in = 1'b0;
               state_in     = ST_COMMIT;
            end else if (scan_ff != used_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end else begin
               cmp_valid_in = 1'b0;
               slot_in      = used_ff[IDX_W-1:0];
               clean_in     = '0;
               bail_in      = '0;
               outcome_in   = (used_ff == CNT_W'(TABLE_ENTRIES)) ? OUT_DROP : OUT_INSERT;
               state_in     = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (outcome_ff == OUT_DROP) begin
                  drop_in               = inc_out;
                  rsp_in.slot_index     = '0;
                  rsp_in.inserted       = 1'b0;
                  rsp_in.dropped        = 1'b1;
                  rsp_in.clean_total    = '0;
                  rsp_in.bail_total     = '0;
                  rsp_in.entries_in_use = USE_W'(used_ff);
                  rsp_in.dropped_total  = inc_out;
               end else begin
                  wr.key_we             = (outcome_ff == OUT_INSERT);
                  wr.stats_we           = 1'b1;
                  used_in               = used_next;
                  rsp_in.slot_index     = SLOT_W'(slot_ff);
                  rsp_in.inserted       = (outcome_ff == OUT_INSERT);
                  rsp_in.dropped        = 1'b0;
                  rsp_in.clean_total    = clean_next;
                  rsp_in.bail_total     = bail_next;
                  rsp_in.entries_in_use = USE_W'(used_next);
                  rsp_in.dropped_total  = drop_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         drop_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         drop_ff      <= drop_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      outcome_ff <= outcome_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      clean_ff   <= clean_in;
      bail_ff    <= bail_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/thct_checker.sv
// ----------------------------------------------------------------------------
// thct_checker
// Port-level checks on the tuple hit-count table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module thct_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire thct_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire thct_pkg::rsp_type rsp_data
);
   import thct_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("new beat taken while an event is in flight");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.inserted && rsp_data.dropped))
      else $error("result both inserted and dropped");

   a_drop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |->
         rsp_data.slot_index == '0 && rsp_data.clean_total == '0 &&
         rsp_data.bail_total == '0 && rsp_data.dropped_total != '0)
      else $error("dropped result carries entry data");

   a_stored_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.dropped |->
         rsp_data.clean_total != '0 || rsp_data.bail_total != '0)
      else $error("stored entry shows no counted outcome");

endmodule

bind tuple_hit_count_table thct_checker u_thct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
